// ===== hdl/humidity_sensor_frame_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the humidity sensor frame decoder
// Concurrent checks that are compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_CORE_ASSERT_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define HSFD_ASSERT_NEVER(label, ck, rn, expr) \
    label: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
        else $error("hsfd assertion failed");

`define HSFD_ASSERT_NEXT(label, ck, rn, cond, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (prop)) \
        else $error("hsfd assertion failed");

`else

`define HSFD_ASSERT_NEVER(label, ck, rn, expr)

`define HSFD_ASSERT_NEXT(label, ck, rn, cond, prop)

`endif

`endif

// ===== hdl/hsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types and constants of the humidity sensor frame decoder.
// ----------------------------------------------------------------------------
package hsfd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_SEED = 8'hFF;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_T_CRC = 2'd1;
    localparam logic [1:0] STATUS_H_CRC = 2'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int OUT_DATA_W = 64;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] temperature_word;
        logic [15:0] humidity_word;
    } frame_rec_t;

endpackage

// ===== hdl/hsfd_front.sv =====
// ----------------------------------------------------------------------------
// hsfd_front
// Tracks the byte position, runs the CRC and assembles one frame record.
// ----------------------------------------------------------------------------
module hsfd_front
    import hsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       beat,
    input  logic [7:0] rx_byte,
    input  logic       frame_start,
    output logic       push,
    output frame_rec_t rec
);

    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    logic [2:0]  pos_reg, pos_next, pos;
    logic [7:0]  crc_reg, crc_next, crc_base, crc_upd;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] hum_reg, hum_next;
    logic        tgood_reg, tgood_next;
    logic [1:0]  status;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    always_comb
    begin
        pos = frame_start ? POS_T_HI : pos_reg;
        if (pos > POS_H_CRC)
        begin
            pos = POS_T_HI;
        end
        crc_base = (pos inside {POS_T_HI, POS_H_HI}) ? CRC_SEED : crc_reg;
        crc_upd  = crc8_byte(crc_base, rx_byte);

        if (!tgood_reg)
        begin
            status = STATUS_T_CRC;
        end
        else if (crc_reg != rx_byte)
        begin
            status = STATUS_H_CRC;
        end
        else
        begin
            status = STATUS_OK;
        end

        pos_next   = pos_reg;
        crc_next   = crc_reg;
        temp_next  = temp_reg;
        hum_next   = hum_reg;
        tgood_next = tgood_reg;
        push       = 1'b0;

        if (beat)
        begin
            pos_next = pos + 3'd1;
            case (pos)
                POS_T_HI:
                begin
                    crc_next  = crc_upd;
                    temp_next = {rx_byte, 8'h00};
                end
                POS_T_LO:
                begin
                    crc_next  = crc_upd;
                    temp_next = {temp_reg[15:8], rx_byte};
                end
                POS_T_CRC:
                begin
                    tgood_next = (crc_reg == rx_byte);
                    crc_next   = CRC_SEED;
                end
                POS_H_HI:
                begin
                    crc_next = crc_upd;
                    hum_next = {rx_byte, 8'h00};
                end
                POS_H_LO:
                begin
                    crc_next = crc_upd;
                    hum_next = {hum_reg[15:8], rx_byte};
                end
                default:
                begin
                    pos_next = POS_T_HI;
                    crc_next = CRC_SEED;
                    push     = 1'b1;
                end
            endcase
        end

        rec.status           = status;
        rec.temperature_word = temp_reg;
        rec.humidity_word    = hum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_T_HI;
            crc_reg   <= CRC_SEED;
            tgood_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            tgood_reg <= tgood_next;
        end
    end

    always_ff @(posedge clk)
    begin
        temp_reg <= temp_next;
        hum_reg  <= hum_next;
    end

endmodule

// ===== hdl/hsfd_fifo.sv =====
// ----------------------------------------------------------------------------
// hsfd_fifo
// Short queue of frame records between the byte front end and the converter.
// ----------------------------------------------------------------------------
`include "humidity_sensor_frame_decoder_core_assert.svh"

module hsfd_fifo
    import hsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_rec_t rec_in,
    output logic       full,
    output logic       pop_valid,
    input  logic       pop_ready,
    output frame_rec_t rec_out
);

    frame_rec_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;

    always_comb
    begin
        full        = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
        pop_valid   = (count_reg != '0);
        pop         = pop_valid && pop_ready;
        rec_out     = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + FIFO_IDX_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_IDX_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= rec_in;
        end
    end

    `HSFD_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full)
    `HSFD_ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > FIFO_CNT_W'(FIFO_DEPTH))
    `HSFD_ASSERT_NEVER(a_ptr_count, clk, rst_n, wr_ptr_reg != rd_ptr_reg + FIFO_IDX_W'(count_reg))
    `HSFD_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + FIFO_CNT_W'(1))

endmodule

// ===== hdl/hsfd_back.sv =====
// ----------------------------------------------------------------------------
// hsfd_back
// Two-stage converter: scale multiply, then divide by full scale and offset.
// ----------------------------------------------------------------------------
module hsfd_back
    import hsfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  frame_rec_t            in_rec,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int T_SCALE    = 17500;
    localparam int H_SCALE    = 12500;
    localparam int T_OFFSET   = 4500;
    localparam int H_OFFSET   = 600;
    localparam int H_MAX      = 10000;
    localparam int FULL_SCALE = 65535;
    localparam int PROD_W     = 31;

    logic                  s1_valid_reg;
    frame_rec_t            s1_rec_reg;
    logic [PROD_W-1:0]     t_prod_reg, h_prod_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  s2_load;
    logic [15:0]           t_q, h_q;
    logic signed [15:0]    t_c16, h_c16;
    logic [14:0]           t_centi;
    logic [13:0]           h_centi;

    function automatic logic [15:0] div_full_scale(input logic [PROD_W-1:0] x);
        logic [14:0] q0;
        logic [16:0] r0;
        q0 = x[30:16];
        r0 = 17'(x[15:0]) + 17'(q0);
        return 16'(q0) + ((r0 >= 17'(FULL_SCALE)) ? 16'd1 : 16'd0);
    endfunction

    always_comb
    begin
        s2_load  = s1_valid_reg && (!out_valid_reg || m_axis_tready);
        in_ready = !s1_valid_reg || s2_load;

        t_q   = div_full_scale(t_prod_reg);
        h_q   = div_full_scale(h_prod_reg);
        t_c16 = signed'(t_q) - signed'(16'(T_OFFSET));
        h_c16 = signed'(h_q) - signed'(16'(H_OFFSET));

        t_centi = t_c16[14:0];
        if (h_c16[15])
        begin
            h_centi = '0;
        end
        else if (h_c16 > signed'(16'(H_MAX)))
        begin
            h_centi = 14'(H_MAX);
        end
        else
        begin
            h_centi = h_c16[13:0];
        end

        if (s1_rec_reg.status != STATUS_OK)
        begin
            t_centi = '0;
            h_centi = '0;
        end

        out_data_next = {1'b0, s1_rec_reg.humidity_word, s1_rec_reg.temperature_word,
                         h_centi, t_centi, s1_rec_reg.status};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (!out_valid_reg || m_axis_tready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_rec_reg <= in_rec;
            t_prod_reg <= PROD_W'(T_SCALE) * PROD_W'(in_rec.temperature_word);
            h_prod_reg <= PROD_W'(H_SCALE) * PROD_W'(in_rec.humidity_word);
        end
        if (s2_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== hdl/humidity_sensor_frame_decoder_core.sv =====
// Throughput: one byte beat per cycle while the record queue is not full;
// one result beat per six-byte frame. Each record is written into the queue
// as its sixth byte is taken, then passes the scale multiply and divide stages.
// The four-entry record queue lets bytes keep flowing while results stall.
// Reset (rst_n low, asynchronous) clears the byte position, the CRC, the queue
// and the converter valid flags.
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_core
// Checks both CRC-8 words of a six-byte sensor frame and converts the values.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder_core
    import hsfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [7:0] rx_byte
    input  logic                  s_axis_tuser,  // [0] frame_start
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] status, [16:2] temperature_centi, [30:17] humidity_centi,
    // [46:31] temperature_word, [62:47] humidity_word, [63] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic       beat;
    logic       push;
    logic       full;
    logic       q_valid;
    logic       q_ready;
    frame_rec_t push_rec;
    frame_rec_t q_rec;

    assign s_axis_tready = !full;
    assign beat          = s_axis_tvalid && s_axis_tready;

    hsfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat        (beat),
        .rx_byte     (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .push        (push),
        .rec         (push_rec)
    );

    hsfd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rec_in    (push_rec),
        .full      (full),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .rec_out   (q_rec)
    );

    hsfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_rec        (q_rec),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== dv/tb_humidity_sensor_frame_decoder_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for humidity_sensor_frame_decoder_core
// Streams six-byte sensor frames into the decoder and checks every result
// beat against a cycle-free model of the CRC check and the value conversion.
// Frames come directed first, then at random: well-formed frames, frames with
// broken CRCs, aborted frames and stray bytes. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_humidity_sensor_frame_decoder_core;
    import hsfd_pkg::*;

    localparam int BYTE_TARGET  = 2000;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic [1:0]         status;
        logic signed [14:0] temp_centi;
        logic [13:0]        hum_centi;
        logic [15:0]        temp_word;
        logic [15:0]        hum_word;
    } reading_t;

    class frame_result_board;
        reading_t   pending_results[$];
        logic [2:0] byte_pos;
        logic [7:0] crc_acc;
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        logic       temp_crc_ok;
        int         mismatches;
        int         results_seen;
        int         status_count[4];

        function new();
            byte_pos     = 3'd0;
            crc_acc      = CRC_SEED;
            temp_raw     = 16'h0000;
            hum_raw      = 16'h0000;
            temp_crc_ok  = 1'b0;
            mismatches   = 0;
            results_seen = 0;
            status_count = '{default: 0};
        endfunction

        static function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
            logic [7:0] c;
            c = crc ^ b;
            for (int i = 0; i < 8; i++)
                c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            return c;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void take_byte(logic [7:0] b, logic start);
            reading_t    r;
            logic [2:0]  pos;
            int unsigned tw;
            int unsigned hw;
            int          h_val;
            if (start)
                byte_pos = 3'd0;
            pos = (byte_pos > 3'd5) ? 3'd0 : byte_pos;
            case (pos)
                3'd0:
                begin
                    crc_acc  = crc8_step(CRC_SEED, b);
                    temp_raw = {b, 8'h00};
                end
                3'd1:
                begin
                    crc_acc       = crc8_step(crc_acc, b);
                    temp_raw[7:0] = b;
                end
                3'd2:
                begin
                    temp_crc_ok = (crc_acc == b);
                    crc_acc     = CRC_SEED;
                end
                3'd3:
                begin
                    crc_acc = crc8_step(CRC_SEED, b);
                    hum_raw = {b, 8'h00};
                end
                3'd4:
                begin
                    crc_acc      = crc8_step(crc_acc, b);
                    hum_raw[7:0] = b;
                end
                default:
                begin
                end
            endcase
            if (pos != 3'd5)
            begin
                byte_pos = pos + 3'd1;
                return;
            end
            byte_pos = 3'd0;
            if (!temp_crc_ok)
                r.status = STATUS_T_CRC;
            else if (crc_acc != b)
                r.status = STATUS_H_CRC;
            else
                r.status = STATUS_OK;
            crc_acc     = CRC_SEED;
            r.temp_word = temp_raw;
            r.hum_word  = hum_raw;
            if (r.status == STATUS_OK)
            begin
                tw           = temp_raw;
                hw           = hum_raw;
                r.temp_centi = 15'(-4500 + int'((17500 * tw) / 65535));
                h_val        = -600 + int'((12500 * hw) / 65535);
                if (h_val < 0)
                    h_val = 0;
                if (h_val > 10000)
                    h_val = 10000;
                r.hum_centi = 14'(h_val);
            end
            else
            begin
                r.temp_centi = '0;
                r.hum_centi  = '0;
            end
            pending_results.push_back(r);
        endfunction

        function void compare_result(logic [OUT_DATA_W-1:0] d);
            reading_t want;
            if (pending_results.size() == 0)
            begin
                flag($sformatf("unexpected result beat: data %h", d));
                return;
            end
            want = pending_results.pop_front();
            results_seen++;
            status_count[want.status]++;
            if (d[1:0] != want.status || d[16:2] != want.temp_centi
                || d[30:17] != want.hum_centi || d[46:31] != want.temp_word
                || d[62:47] != want.hum_word)
                flag($sformatf({"result %0d: expected status %0d temp %0d hum %0d words %h %h,",
                                " got status %0d temp %0d hum %0d words %h %h"},
                               results_seen, want.status, want.temp_centi, want.hum_centi,
                               want.temp_word, want.hum_word, d[1:0], $signed(d[16:2]),
                               d[30:17], d[46:31], d[62:47]));
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = 8'h00;  // [7:0] rx_byte
    logic                  s_axis_tuser  = 1'b0;   // [0] frame_start
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    frame_result_board board = new();
    bit quiet_run   = 1'b0;
    int cycle_count = 0;
    int bytes_sent  = 0;

    humidity_sensor_frame_decoder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.take_byte(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                board.compare_result(m_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_humidity_sensor_frame_decoder_core: done, errors");
            $finish;
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_run || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function logic [15:0] pick_temperature();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    function logic [15:0] pick_humidity();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 16'($urandom_range(3100, 3200));
        if (r < 4)
            return 16'($urandom_range(55500, 55650));
        return 16'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [15:0] t, input logic [15:0] h,
                              input logic bad_t, input logic bad_h, input logic start);
        logic [7:0] ct;
        logic [7:0] ch;
        ct = frame_result_board::crc8_step(frame_result_board::crc8_step(CRC_SEED, t[15:8]),
                                           t[7:0]);
        ch = frame_result_board::crc8_step(frame_result_board::crc8_step(CRC_SEED, h[15:8]),
                                           h[7:0]);
        if (bad_t)
            ct ^= 8'(1 << $urandom_range(0, 7));
        if (bad_h)
            ch ^= 8'(1 << $urandom_range(0, 7));
        send_byte(t[15:8], start);
        send_byte(t[7:0], 1'b0);
        send_byte(ct, 1'b0);
        send_byte(h[15:8], 1'b0);
        send_byte(h[7:0], 1'b0);
        send_byte(ch, 1'b0);
    endtask

    initial
    begin
        int         kind;
        int         n;
        logic [1:0] bad;
        logic       need_start;
        need_start = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Coldest reading with humidity clamped low, then hottest with humidity
        // clamped high sent without a start flag, relying on the position wrap.
        send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
        send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        send_frame(16'h1234, 16'h5678, 1'b1, 1'b1, 1'b1);
        // A new start in the middle of a frame drops the partial frame.
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b1);

        while (bytes_sent < BYTE_TARGET)
        begin
            if ($urandom_range(0, 39) == 0)
                quiet_run = ~quiet_run;
            kind = $urandom_range(0, 99);
            if (kind < 72)
            begin
                send_frame(pick_temperature(), pick_humidity(), 1'b0, 1'b0,
                           need_start || ($urandom_range(0, 3) != 0));
                need_start = 1'b0;
            end
            else if (kind < 84)
            begin
                bad = 2'($urandom_range(1, 3));
                send_frame(pick_temperature(), pick_humidity(), bad[0], bad[1], 1'b1);
                need_start = 1'b0;
            end
            else if (kind < 92)
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom_range(0, 255)), i == 0);
                need_start = 1'b1;
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                need_start = 1'b1;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d byte beats; checked %0d results: %0d ok, %0d temperature CRC, %0d %s",
                 bytes_sent, board.results_seen, board.status_count[STATUS_OK],
                 board.status_count[STATUS_T_CRC], board.status_count[STATUS_H_CRC],
                 "humidity CRC");
        $display("Mismatches: %0d", board.mismatches);
        if (board.mismatches == 0)
            $display("tb_humidity_sensor_frame_decoder_core: done, clean");
        else
            $display("tb_humidity_sensor_frame_decoder_core: done, errors");
        $finish;
    end

endmodule
